### hdl/ljpe_pkg.sv
// ----------------------------------------------------------------------------
// ljpe_pkg
// shared types, widths and constants for the lennard-jones pair energy block
// ----------------------------------------------------------------------------
package ljpe_pkg;

    localparam int POS_W     = 32;   // q16.16 positions and parameters
    localparam int D_W       = 33;   // position difference
    localparam int LANE_W    = 21;   // one packed matrix entry
    localparam int ROW_W     = 63;   // three packed lanes
    localparam int S_W       = 35;   // fractional part, q.35
    localparam int W_W       = 36;   // wrapped fraction, signed
    localparam int V_W       = 60;   // cartesian accumulation
    localparam int R_W       = 31;   // cartesian component, q.16
    localparam int R_SHIFT   = 29;
    localparam int RSQ_W     = 57;   // squared distance, q.32
    localparam int SQ_W      = 64;   // sigma^2 and cutoff^2
    localparam int REM_W     = 58;   // divider remainder
    localparam int Q_W       = 22;   // quotient sigma^2/rsq, q.16
    localparam int Q2_W      = 28;
    localparam int Q3_W      = 34;
    localparam int Q_CAP_SH  = 6;    // quotient cap of 64 as a shift
    localparam int DIV_STEPS = 22;
    localparam int CNT_W     = 5;
    localparam int MA_W      = 37;   // multiplier operand a
    localparam int MB_W      = 34;   // multiplier operand b
    localparam int P_W       = MA_W + MB_W;
    localparam int E_W       = 64;   // q32.32 energy
    localparam int HL_W      = 63;   // partial products of the output scale
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;

    localparam logic signed [POS_W-1:0] PARAM_MIN   = 32'sd7;
    localparam logic [RSQ_W-1:0]        OVERLAP_RSQ = 57'd429497;
    localparam logic [S_W-1:0]          FRAC_HALF   = 35'h4_0000_0000;
    localparam logic [W_W-1:0]          FRAC_ONE    = 36'h8_0000_0000;
    localparam logic [E_W-1:0]          E_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [E_W-1:0]          E_MIN       = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        REG_CELL_A = 3'd0,
        REG_CELL_B = 3'd1,
        REG_CELL_C = 3'd2,
        REG_INV_A  = 3'd3,
        REG_INV_B  = 3'd4,
        REG_INV_C  = 3'd5,
        REG_SIG_CUT = 3'd6,
        REG_EPS    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        M_NONE, M_SIG, M_CUT, M_FRAC, M_CART, M_SQ, M_Q2, M_Q3, M_TERM, M_HI, M_LO
    } t_mul_op;

    typedef enum logic [3:0] {
        P_NONE, P_SIG, P_CUT, P_FRAC, P_CART, P_SQ, P_OVL, P_TMAX,
        P_DIV_INIT, P_DIV, P_Q2, P_Q3, P_TERM, P_ACC, P_HI, P_LO
    } t_post_op;

    typedef struct packed {
        t_mul_op          mul;
        t_post_op         post;
        logic [1:0]       row;
        logic [1:0]       col;
        logic [CNT_W-1:0] idx;
        logic             load;
        logic             fin;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic cut_out;
        logic tiny;
        logic big;
        logic q3_big;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [2:0][ROW_W-1:0] cell_row;
        logic [2:0][ROW_W-1:0] inv;
        logic [POS_W-1:0]      sig;
        logic [POS_W-1:0]      cut;
        logic [POS_W-1:0]      eps;
    } t_cfg;

    function automatic logic signed [LANE_W-1:0] lane_of(input logic [ROW_W-1:0] row,
                                                         input logic [1:0] k);
        return row[k*LANE_W +: LANE_W];
    endfunction

endpackage

### hdl/ljpe_datapath.sv
// ----------------------------------------------------------------------------
// ljpe_datapath
// shared multiplier, bit-serial divider, accumulator and result register
// ----------------------------------------------------------------------------
module ljpe_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ljpe_pkg::t_cfg                   i_cfg,
    input  ljpe_pkg::t_cmd                   i_cmd,
    output ljpe_pkg::t_status                o_status,
    input  logic signed [ljpe_pkg::POS_W-1:0] i_first_x,
    input  logic signed [ljpe_pkg::POS_W-1:0] i_first_y,
    input  logic signed [ljpe_pkg::POS_W-1:0] i_first_z,
    input  logic signed [ljpe_pkg::POS_W-1:0] i_second_x,
    input  logic signed [ljpe_pkg::POS_W-1:0] i_second_y,
    input  logic signed [ljpe_pkg::POS_W-1:0] i_second_z,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [ljpe_pkg::E_W-1:0]   o_total_energy,
    output logic                             o_overlap,
    output logic                             o_saturated
);
    import ljpe_pkg::*;

    logic signed [D_W-1:0]   r_d [3];
    logic [S_W-1:0]          r_s;
    logic signed [W_W-1:0]   r_w [3];
    logic signed [V_W-1:0]   r_v;
    logic signed [R_W-1:0]   r_r [3];
    logic [RSQ_W-1:0]        r_rsq;
    logic [SQ_W-1:0]         r_sig2;
    logic [SQ_W-1:0]         r_cut2;
    logic [REM_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_q;
    logic [Q2_W-1:0]         r_q2;
    logic [Q3_W-1:0]         r_q3;
    logic [E_W-1:0]          r_term;
    logic [E_W-1:0]          r_sum;
    logic                    r_ovl_seen;
    logic                    r_clip_seen;
    logic [HL_W-1:0]         r_hi;
    logic [HL_W-1:0]         r_lo;
    logic signed [P_W-1:0]   r_prod;
    t_post_op                r_post;
    logic [1:0]              r_prow;
    logic [1:0]              r_pcol;
    logic [CNT_W-1:0]        r_pidx;
    logic                    r_out_valid;
    logic [E_W-1:0]          r_energy;
    logic                    r_ovl_out;
    logic                    r_sat_out;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   mul_p;
    logic                    cfg_valid;
    logic                    sum_neg;
    logic [E_W-1:0]          mag;
    logic [S_W-1:0]          frac_s;
    logic [W_W-1:0]          frac_w;
    logic signed [V_W-1:0]   cart_v;
    logic [RSQ_W-1:0]        sq_rsq;
    logic                    div_bit;
    logic [REM_W-1:0]        div_rem2;
    logic                    div_ge;
    logic [E_W-1:0]          term_a;
    logic [E_W-1:0]          term_b;
    logic [E_W-1:0]          term_d;
    logic                    term_clip;
    logic [E_W-1:0]          acc_raw;
    logic                    acc_ovf;
    logic                    hi_big;
    logic [E_W-1:0]          scaled;
    logic [E_W-1:0]          limit;
    logic                    scale_ovf;
    logic [E_W-1:0]          scale_mag;
    logic [E_W-1:0]          fin_energy;
    logic                    fin_ovl;
    logic                    fin_sat;

    // parameter gate
    assign cfg_valid = ($signed(i_cfg.eps) >= PARAM_MIN) && ($signed(i_cfg.sig) >= PARAM_MIN)
                    && ($signed(i_cfg.cut) >= PARAM_MIN);

    assign sum_neg = r_sum[E_W-1];
    assign mag     = sum_neg ? (~r_sum + 64'd1) : r_sum;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul)
            M_SIG: begin
                mul_a = MA_W'($signed(i_cfg.sig));
                mul_b = MB_W'($signed(i_cfg.sig));
            end
            M_CUT: begin
                mul_a = MA_W'($signed(i_cfg.cut));
                mul_b = MB_W'($signed(i_cfg.cut));
            end
            M_FRAC: begin
                mul_a = MA_W'(r_d[i_cmd.col]);
                mul_b = MB_W'(lane_of(i_cfg.inv[i_cmd.row], i_cmd.col));
            end
            M_CART: begin
                mul_a = MA_W'(r_w[i_cmd.col]);
                mul_b = MB_W'(lane_of(i_cfg.cell_row[i_cmd.row], i_cmd.col));
            end
            M_SQ: begin
                mul_a = MA_W'(r_r[i_cmd.row]);
                mul_b = MB_W'(r_r[i_cmd.row]);
            end
            M_Q2: begin
                mul_a = $signed({{(MA_W-Q_W){1'b0}}, r_q});
                mul_b = $signed({{(MB_W-Q_W){1'b0}}, r_q});
            end
            M_Q3: begin
                mul_a = $signed({{(MA_W-Q2_W){1'b0}}, r_q2});
                mul_b = $signed({{(MB_W-Q_W){1'b0}}, r_q});
            end
            M_TERM: begin
                mul_a = $signed({{(MA_W-32){1'b0}}, r_q3[31:0]});
                mul_b = $signed({{(MB_W-32){1'b0}}, r_q3[31:0]});
            end
            M_HI: begin
                mul_a = MA_W'($signed(i_cfg.eps));
                mul_b = $signed({{(MB_W-32){1'b0}}, mag[63:32]});
            end
            M_LO: begin
                mul_a = MA_W'($signed(i_cfg.eps));
                mul_b = $signed({{(MB_W-32){1'b0}}, mag[31:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // post-processing of the registered product
    always_comb begin
        frac_s   = ((r_pcol == 2'd0) ? '0 : r_s) + r_prod[S_W-1:0];
        frac_w   = {1'b0, frac_s} - ((frac_s > FRAC_HALF) ? FRAC_ONE : '0);
        cart_v   = ((r_pcol == 2'd0) ? '0 : r_v) + r_prod[V_W-1:0];
        sq_rsq   = ((r_prow == 2'd0) ? '0 : r_rsq) + r_prod[RSQ_W-1:0];
        div_bit  = r_pidx[4] ? r_sig2[r_pidx[2:0]] : 1'b0;
        div_rem2 = {r_rem[REM_W-2:0], div_bit};
        div_ge   = div_rem2 >= {1'b0, r_rsq};
        term_a   = r_prod[E_W-1:0];
        term_b   = {16'd0, r_q3[31:0], 16'd0};
        term_d   = term_a - term_b;
        term_clip = (term_a >= term_b) && term_d[E_W-1];
        acc_raw  = r_sum + r_term;
        acc_ovf  = (r_sum[E_W-1] == r_term[E_W-1]) && (acc_raw[E_W-1] != r_sum[E_W-1]);
    end

    // output scaling by epsilon (four times eps, q16.16 to q32.32)
    always_comb begin
        hi_big     = |r_hi[HL_W-1:45];
        scaled     = {1'b0, r_hi[44:0], 18'd0} + {15'd0, r_lo[HL_W-1:14]};
        limit      = sum_neg ? E_MIN : E_MAX;
        scale_ovf  = hi_big || (scaled > limit);
        scale_mag  = scale_ovf ? limit : scaled;
        if (!cfg_valid) begin
            fin_energy = '0;
            fin_ovl    = 1'b0;
            fin_sat    = 1'b0;
        end else if (r_ovl_seen) begin
            fin_energy = '0;
            fin_ovl    = 1'b1;
            fin_sat    = r_clip_seen;
        end else begin
            fin_energy = sum_neg ? (~scale_mag + 64'd1) : scale_mag;
            fin_ovl    = 1'b0;
            fin_sat    = r_clip_seen | scale_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post      <= P_NONE;
            r_sum       <= '0;
            r_ovl_seen  <= 1'b0;
            r_clip_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= mul_p;
            r_post <= i_cmd.post;
            r_prow <= i_cmd.row;
            r_pcol <= i_cmd.col;
            r_pidx <= i_cmd.idx;

            if (i_cmd.load) begin
                r_d[0] <= D_W'(i_first_x) - D_W'(i_second_x);
                r_d[1] <= D_W'(i_first_y) - D_W'(i_second_y);
                r_d[2] <= D_W'(i_first_z) - D_W'(i_second_z);
            end

            case (r_post)
                P_SIG: r_sig2 <= r_prod[SQ_W-1:0];
                P_CUT: r_cut2 <= r_prod[SQ_W-1:0];
                P_FRAC: begin
                    r_s <= frac_s;
                    if (r_pcol == 2'd2) begin
                        r_w[r_prow] <= frac_w;
                    end
                end
                P_CART: begin
                    r_v <= cart_v;
                    if (r_pcol == 2'd2) begin
                        r_r[r_prow] <= cart_v[V_W-1:R_SHIFT];
                    end
                end
                P_SQ: r_rsq <= sq_rsq;
                P_OVL: r_ovl_seen <= 1'b1;
                P_TMAX: begin
                    r_term      <= E_MAX;
                    r_clip_seen <= 1'b1;
                end
                P_DIV_INIT: begin
                    r_rem <= REM_W'(r_sig2 >> Q_CAP_SH);
                    r_q   <= '0;
                end
                P_DIV: begin
                    r_rem <= div_ge ? (div_rem2 - {1'b0, r_rsq}) : div_rem2;
                    r_q   <= {r_q[Q_W-2:0], div_ge};
                end
                P_Q2: r_q2 <= r_prod[Q2_W+15:16];
                P_Q3: r_q3 <= r_prod[Q3_W+15:16];
                P_TERM: begin
                    r_term <= term_clip ? E_MAX : term_d;
                    if (term_clip) begin
                        r_clip_seen <= 1'b1;
                    end
                end
                P_ACC: begin
                    if (acc_ovf) begin
                        r_sum       <= r_sum[E_W-1] ? E_MIN : E_MAX;
                        r_clip_seen <= 1'b1;
                    end else begin
                        r_sum <= acc_raw;
                    end
                end
                P_HI: r_hi <= r_prod[HL_W-1:0];
                P_LO: r_lo <= r_prod[HL_W-1:0];
                default: ;
            endcase

            if (i_cmd.fin) begin
                r_energy    <= fin_energy;
                r_ovl_out   <= fin_ovl;
                r_sat_out   <= fin_sat;
                r_out_valid <= 1'b1;
                r_sum       <= '0;
                r_ovl_seen  <= 1'b0;
                r_clip_seen <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.valid    = cfg_valid;
    assign o_status.cut_out  = {{(SQ_W-RSQ_W){1'b0}}, r_rsq} >= r_cut2;
    assign o_status.tiny     = r_rsq < OVERLAP_RSQ;
    assign o_status.big      = r_sig2 >= {1'b0, r_rsq, {Q_CAP_SH{1'b0}}};
    assign o_status.q3_big   = |r_q3[Q3_W-1:32];
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_total_energy = r_energy;
    assign o_overlap      = r_ovl_out;
    assign o_saturated    = r_sat_out;

endmodule

### hdl/ljpe_ctrl.sv
// ----------------------------------------------------------------------------
// ljpe_ctrl
// sequencer that steps the datapath through one pair item
// ----------------------------------------------------------------------------
module ljpe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_has_pair,
    input  logic              i_last_pair,
    output logic              o_in_ready,
    input  ljpe_pkg::t_status i_status,
    output ljpe_pkg::t_cmd    o_cmd
);
    import ljpe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SIG, S_CUT, S_FRAC, S_CART, S_SQ, S_DRAIN_SQ, S_CHECK,
        S_DIV, S_DRAIN_DIV, S_Q2, S_DRAIN_Q2, S_Q3, S_DRAIN_Q3, S_Q3_CHECK,
        S_TERM, S_ACC, S_DONE, S_OUT_HI, S_OUT_LO, S_DRAIN_OUT, S_FIN
    } t_state;

    t_state           r_state;
    logic [1:0]       r_row;
    logic [1:0]       r_col;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cmd.row  = r_row;
        o_cmd.col  = r_col;
        o_cmd.idx  = r_cnt;
        unique case (r_state)
            S_IDLE:   o_cmd.load = i_in_valid;
            S_SIG: begin
                o_cmd.mul  = M_SIG;
                o_cmd.post = P_SIG;
            end
            S_CUT: begin
                o_cmd.mul  = M_CUT;
                o_cmd.post = P_CUT;
            end
            S_FRAC: begin
                o_cmd.mul  = M_FRAC;
                o_cmd.post = P_FRAC;
            end
            S_CART: begin
                o_cmd.mul  = M_CART;
                o_cmd.post = P_CART;
            end
            S_SQ: begin
                o_cmd.mul  = M_SQ;
                o_cmd.post = P_SQ;
            end
            S_CHECK: begin
                if (i_status.cut_out) begin
                    o_cmd.post = P_NONE;
                end else if (i_status.tiny) begin
                    o_cmd.post = P_OVL;
                end else if (i_status.big) begin
                    o_cmd.post = P_TMAX;
                end else begin
                    o_cmd.post = P_DIV_INIT;
                end
            end
            S_DIV:    o_cmd.post = P_DIV;
            S_Q2: begin
                o_cmd.mul  = M_Q2;
                o_cmd.post = P_Q2;
            end
            S_Q3: begin
                o_cmd.mul  = M_Q3;
                o_cmd.post = P_Q3;
            end
            S_Q3_CHECK: begin
                if (i_status.q3_big) begin
                    o_cmd.post = P_TMAX;
                end
            end
            S_TERM: begin
                o_cmd.mul  = M_TERM;
                o_cmd.post = P_TERM;
            end
            S_ACC:    o_cmd.post = P_ACC;
            S_OUT_HI: begin
                o_cmd.mul  = M_HI;
                o_cmd.post = P_HI;
            end
            S_OUT_LO: begin
                o_cmd.mul  = M_LO;
                o_cmd.post = P_LO;
            end
            S_FIN:    o_cmd.fin = i_status.out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_row <= '0;
                    r_col <= '0;
                    if (i_in_valid) begin
                        r_last <= i_last_pair;
                        if (i_has_pair && i_status.valid) begin
                            r_state <= S_SIG;
                        end else if (i_last_pair) begin
                            r_state <= S_OUT_HI;
                        end
                    end
                end
                S_SIG: r_state <= S_CUT;
                S_CUT: r_state <= S_FRAC;
                S_FRAC, S_CART: begin
                    if (r_col == 2'd2) begin
                        r_col <= '0;
                        if (r_row == 2'd2) begin
                            r_row   <= '0;
                            r_state <= (r_state == S_FRAC) ? S_CART : S_SQ;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_SQ: begin
                    if (r_row == 2'd2) begin
                        r_row   <= '0;
                        r_state <= S_DRAIN_SQ;
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                end
                S_DRAIN_SQ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_status.cut_out || i_status.tiny) begin
                        r_state <= S_DONE;
                    end else if (i_status.big) begin
                        r_state <= S_ACC;
                    end else begin
                        r_cnt   <= CNT_W'(DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DRAIN_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DRAIN_DIV: r_state <= S_Q2;
                S_Q2:        r_state <= S_DRAIN_Q2;
                S_DRAIN_Q2:  r_state <= S_Q3;
                S_Q3:        r_state <= S_DRAIN_Q3;
                S_DRAIN_Q3:  r_state <= S_Q3_CHECK;
                S_Q3_CHECK:  r_state <= i_status.q3_big ? S_ACC : S_TERM;
                S_TERM:      r_state <= S_ACC;
                S_ACC:       r_state <= S_DONE;
                S_DONE:      r_state <= r_last ? S_OUT_HI : S_IDLE;
                S_OUT_HI:    r_state <= S_OUT_LO;
                S_OUT_LO:    r_state <= S_DRAIN_OUT;
                S_DRAIN_OUT: r_state <= S_FIN;
                S_FIN: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/lennard_jones_pair_energy.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy
// lennard-jones 12-6 energy over a stream of atom pairs, minimum image
//
// Each item carries one atom pair (q16.16 positions). The pair difference is
// taken to fractional coordinates through the inverse cell, wrapped into the
// unit interval around zero, taken back through the cell and squared. Inside
// the cutoff the term q^3*(q^3-1), q = sigma^2/r^2, goes into a saturating
// q32.32 sum; a pair closer than 0.01 raises the overlap flag instead. The
// item with last_pair set produces one result item, 4*eps*sum, and clears the
// sum and flags. One item is worked on at a time, all products going through
// a single shared 37x34 multiplier and the quotient through a bit-serial
// divider of 22 steps. A pair outside the cutoff or overlapping skips the
// divider and the term, one whose term clips early skips the divider, and one
// whose q^3 clips skips the final term product; an item without a pair is
// taken straight in idle. A closing item then runs the output scaling and waits for
// the result register to free up. The result register holds the finished item,
// so the next item is taken while the previous result is still pending.
// Configuration is an apb-style port with 64-bit data, register i at byte
// address 8*i.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ljpe_pkg::ADDR_W-1:0]        paddr,
    input  logic [ljpe_pkg::DATA_W-1:0]        pwdata,
    output logic [ljpe_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    // pair items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [ljpe_pkg::POS_W-1:0]  i_first_x,
    input  logic signed [ljpe_pkg::POS_W-1:0]  i_first_y,
    input  logic signed [ljpe_pkg::POS_W-1:0]  i_first_z,
    input  logic signed [ljpe_pkg::POS_W-1:0]  i_second_x,
    input  logic signed [ljpe_pkg::POS_W-1:0]  i_second_y,
    input  logic signed [ljpe_pkg::POS_W-1:0]  i_second_z,
    input  logic                               i_has_pair,
    input  logic                               i_last_pair,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ljpe_pkg::E_W-1:0]    o_total_energy,
    output logic                               o_overlap,
    output logic                               o_saturated
);
    import ljpe_pkg::*;

    // configuration registers
    logic [ROW_W-1:0]  r_cell [3];
    logic [ROW_W-1:0]  r_inv  [3];
    logic [DATA_W-1:0] r_sig_cut;
    logic [POS_W-1:0]  r_eps;

    logic     cfg_wr;
    t_reg_idx cfg_idx;
    t_cfg     cfg;
    t_cmd     cmd;
    t_status  status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    // register writes land in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell[0] <= '0;
            r_cell[1] <= '0;
            r_cell[2] <= '0;
            r_inv[0]  <= '0;
            r_inv[1]  <= '0;
            r_inv[2]  <= '0;
            r_sig_cut <= '0;
            r_eps     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CELL_A:  r_cell[0] <= pwdata[ROW_W-1:0];
                REG_CELL_B:  r_cell[1] <= pwdata[ROW_W-1:0];
                REG_CELL_C:  r_cell[2] <= pwdata[ROW_W-1:0];
                REG_INV_A:   r_inv[0]  <= pwdata[ROW_W-1:0];
                REG_INV_B:   r_inv[1]  <= pwdata[ROW_W-1:0];
                REG_INV_C:   r_inv[2]  <= pwdata[ROW_W-1:0];
                REG_SIG_CUT: r_sig_cut <= pwdata;
                REG_EPS:     r_eps     <= pwdata[POS_W-1:0];
                default:     ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (cfg_idx)
            REG_CELL_A:  prdata = {1'b0, r_cell[0]};
            REG_CELL_B:  prdata = {1'b0, r_cell[1]};
            REG_CELL_C:  prdata = {1'b0, r_cell[2]};
            REG_INV_A:   prdata = {1'b0, r_inv[0]};
            REG_INV_B:   prdata = {1'b0, r_inv[1]};
            REG_INV_C:   prdata = {1'b0, r_inv[2]};
            REG_SIG_CUT: prdata = r_sig_cut;
            REG_EPS:     prdata = {{(DATA_W-POS_W){1'b0}}, r_eps};
            default:     prdata = '0;
        endcase
    end

    // sigma in the upper half, cutoff in the lower half
    always_comb begin
        cfg.cell_row[0] = r_cell[0];
        cfg.cell_row[1] = r_cell[1];
        cfg.cell_row[2] = r_cell[2];
        cfg.inv[0]      = r_inv[0];
        cfg.inv[1]      = r_inv[1];
        cfg.inv[2]      = r_inv[2];
        cfg.sig         = r_sig_cut[DATA_W-1:POS_W];
        cfg.cut         = r_sig_cut[POS_W-1:0];
        cfg.eps         = r_eps;
    end

    ljpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_has_pair  (i_has_pair),
        .i_last_pair (i_last_pair),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ljpe_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_first_z      (i_first_z),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_second_z     (i_second_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_total_energy (o_total_energy),
        .o_overlap      (o_overlap),
        .o_saturated    (o_saturated)
    );

endmodule

### tb/tb_lennard_jones_pair_energy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lennard_jones_pair_energy
// self-checking bench for the lennard-jones pair energy block
//
// Pair items go to the block from a queue of pending items through a clocked
// driver. A predictor computes the expected result item of every closing item
// at accept time. A clocked monitor compares each result against the oldest
// expected one. The run steps through several register settings and several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_lennard_jones_pair_energy;
    import ljpe_pkg::*;

    typedef struct {
        bit [31:0] fx, fy, fz, sx, sy, sz;
        bit        has_pair, last_pair;
    } pair_item_t;

    typedef struct {
        longint energy;
        bit     overlap;
        bit     saturated;
    } energy_res_t;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam longint UNIT    = 65536;   // 1.0 in q16.16

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        o_in_ready;
    logic [31:0] first_x = 0, first_y = 0, first_z = 0;
    logic [31:0] second_x = 0, second_y = 0, second_z = 0;
    logic        has_pair = 0, last_pair = 0;
    logic        o_out_valid;
    logic        out_ready = 0;
    logic signed [E_W-1:0] o_total_energy;
    logic        o_overlap, o_saturated;

    lennard_jones_pair_energy i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_first_x(first_x), .i_first_y(first_y), .i_first_z(first_z),
        .i_second_x(second_x), .i_second_y(second_y), .i_second_z(second_z),
        .i_has_pair(has_pair), .i_last_pair(last_pair),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_total_energy(o_total_energy), .o_overlap(o_overlap),
        .o_saturated(o_saturated)
    );

    // predictor copy of the registers and the running sum
    bit [63:0]   lj_regs [8];
    longint      lj_sum;
    bit          lj_overlap, lj_clip;

    pair_item_t  pending_pairs [$];
    energy_res_t expected_energy [$];
    pair_item_t  cur;
    int          snd_pct = 0, rcv_pct = 0;   // idle and stall chance in percent
    bit          hold_off = 0;
    int          n_accepted = 0, n_results = 0, n_mismatch = 0, n_overlap = 0;
    int          n_sat = 0;

    // ---------------------------------------------------------------- predictor
    function automatic longint lane_val(bit [63:0] row, int k);
        logic signed [20:0] l;
        l = row[k*21 +: 21];
        return longint'(l);
    endfunction

    function automatic longint sign32(bit [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sum_clip(longint a, longint b, inout bit clip);
        if (b > 0 && a > I64_MAX - b) begin
            clip = 1;
            return I64_MAX;
        end
        if (b < 0 && a < I64_MIN - b) begin
            clip = 1;
            return I64_MIN;
        end
        return a + b;
    endfunction

    // q^3*(q^3-1) in q32.32 with q = sig2/rsq in q16.16
    function automatic longint lj_term(bit [63:0] sig2, bit [63:0] rsq, inout bit clip);
        bit [63:0] q, rem, q2, q3, a, b, d;
        if (sig2 >= 64 * rsq) begin
            clip = 1;
            return I64_MAX;
        end
        q   = sig2 / rsq;
        rem = sig2 % rsq;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= rsq) begin
                rem = rem - rsq;
                q[0] = 1'b1;
            end
        end
        q2 = (q * q) >> 16;
        q3 = (q2 * q) >> 16;
        if (q3 >= 64'h1_0000_0000) begin
            clip = 1;
            return I64_MAX;
        end
        a = q3 * q3;
        b = q3 << 16;
        if (a >= b) begin
            d = a - b;
            if (d > 64'h7FFF_FFFF_FFFF_FFFF) begin
                clip = 1;
                return I64_MAX;
            end
            return longint'(d);
        end
        return -longint'(b - a);
    endfunction

    // 4*eps*sum, magnitude truncated toward zero
    function automatic longint energy_scale(longint s, bit [63:0] eps, inout bit clip);
        bit        neg;
        bit [63:0] mag, lim, hi, lo, m;
        neg = s < 0;
        mag = neg ? -s : s;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        hi  = (mag >> 32) * eps;
        lo  = (mag & 64'hFFFF_FFFF) * eps;
        if (hi >= 64'h2000_0000_0000) begin
            clip = 1;
            m = lim;
        end else begin
            m = (hi << 18) + (lo >> 14);
            if (m > lim) begin
                clip = 1;
                m = lim;
            end
        end
        return neg ? longint'(-m) : longint'(m);
    endfunction

    function automatic void add_pair_energy(pair_item_t it, bit [63:0] sig2, bit [63:0] cut2);
        longint    d [3], w [3];
        longint    s, v, r, t;
        bit [63:0] f, m, rsq;
        d[0] = sign32(it.fx) - sign32(it.sx);
        d[1] = sign32(it.fy) - sign32(it.sy);
        d[2] = sign32(it.fz) - sign32(it.sz);
        rsq = 0;
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += lane_val(lj_regs[3 + i], j) * d[j];
            f = s & 64'h7_FFFF_FFFF;
            // minimum image: exactly minus one half lands on plus one half
            w[i] = (f > 64'h4_0000_0000) ? longint'(f) - 64'sh8_0000_0000 : longint'(f);
        end
        for (int i = 0; i < 3; i++) begin
            v = 0;
            for (int j = 0; j < 3; j++)
                v += lane_val(lj_regs[i], j) * w[j];
            r = v >>> 29;
            m = r < 0 ? -r : r;
            rsq += m * m;
        end
        if (rsq >= cut2)
            return;
        if (rsq < 64'd429497) begin
            lj_overlap = 1;
            return;
        end
        // term first so its clip flag is seen by the accumulation
        t = lj_term(sig2, rsq, lj_clip);
        lj_sum = sum_clip(lj_sum, t, lj_clip);
    endfunction

    function automatic void predict_energy(pair_item_t it);
        longint      eps, sig, cutr;
        bit          ok, clip;
        energy_res_t res;
        eps  = sign32(lj_regs[REG_EPS][31:0]);
        sig  = sign32(lj_regs[REG_SIG_CUT][63:32]);
        cutr = sign32(lj_regs[REG_SIG_CUT][31:0]);
        ok   = eps >= 7 && sig >= 7 && cutr >= 7;
        if (it.has_pair && ok)
            add_pair_energy(it, sig * sig, cutr * cutr);
        if (!it.last_pair)
            return;
        res = '{0, 0, 0};
        if (ok && lj_overlap) begin
            res.overlap   = 1;
            res.saturated = lj_clip;
        end else if (ok) begin
            clip = lj_clip;
            res.energy    = energy_scale(lj_sum, eps, clip);
            res.saturated = clip;
        end
        expected_energy.push_back(res);
        lj_sum = 0;
        lj_overlap = 0;
        lj_clip = 0;
    endfunction

    // ---------------------------------------------------------------- clock, limit
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("timeout after %0d items accepted", n_accepted);
        $display("end of test: mismatches");
        $finish;
    end

    // long receiver hold-off once the run is well under way
    initial begin
        wait (n_accepted >= 400);
        @(posedge i_clk);
        hold_off = 1;
        repeat (500) @(posedge i_clk);
        hold_off = 0;
    end

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_energy(cur);
                n_accepted++;
            end
            // payload only changes once the held item has gone in
            if (!in_valid || o_in_ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= snd_pct) begin
                    cur = pending_pairs.pop_front();
                    in_valid  <= 1;
                    first_x   <= cur.fx;
                    first_y   <= cur.fy;
                    first_z   <= cur.fz;
                    second_x  <= cur.sx;
                    second_y  <= cur.sy;
                    second_z  <= cur.sz;
                    has_pair  <= cur.has_pair;
                    last_pair <= cur.last_pair;
                end else begin
                    in_valid <= 0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        energy_res_t e;
        if (!i_rst_n) begin
            out_ready <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_results++;
                if (o_overlap) n_overlap++;
                if (o_saturated) n_sat++;
                if (expected_energy.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result item: energy %h overlap %b sat %b",
                                 o_total_energy, o_overlap, o_saturated);
                end else begin
                    e = expected_energy.pop_front();
                    if (o_total_energy !== e.energy || o_overlap !== e.overlap ||
                        o_saturated !== e.saturated) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("result %0d: expected %h/%b/%b got %h/%b/%b",
                                     n_results, e.energy, e.overlap, e.saturated,
                                     o_total_energy, o_overlap, o_saturated);
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(0, 99) >= rcv_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic bit [63:0] pack_row(longint a, longint b, longint c);
        bit [63:0] r;
        r = 0;
        r[20:0]  = a[20:0];
        r[41:21] = b[20:0];
        r[62:42] = c[20:0];
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, bit [63:0] val);
        @(posedge i_clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (idx)
            REG_SIG_CUT: lj_regs[idx] = val;
            REG_EPS:     lj_regs[idx] = val & 64'hFFFF_FFFF;
            default:     lj_regs[idx] = val & 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
    endtask

    // cubic box of edge len units, optional skew on the cell rows
    task automatic set_box(int len, bit skew, bit [31:0] sig, bit [31:0] cutr, bit [31:0] eps);
        longint c, iv;
        c  = longint'(len) * 1024;
        iv = (longint'(1) << 19) / len;
        write_reg(REG_CELL_A, pack_row(c, skew ? $urandom_range(0, 4000) : 0, 0));
        write_reg(REG_CELL_B, pack_row(0, c, skew ? -longint'($urandom_range(0, 4000)) : 0));
        write_reg(REG_CELL_C, pack_row(0, 0, c));
        write_reg(REG_INV_A, pack_row(iv, 0, 0));
        write_reg(REG_INV_B, pack_row(0, iv, 0));
        write_reg(REG_INV_C, pack_row(0, 0, iv));
        write_reg(REG_SIG_CUT, {sig, cutr});
        write_reg(REG_EPS, {32'd0, eps});
    endtask

    task automatic push_pair(longint f[3], longint d[3], bit hp, bit lp);
        pair_item_t it;
        it.fx = 32'(f[0]); it.fy = 32'(f[1]); it.fz = 32'(f[2]);
        it.sx = 32'(f[0] - d[0]); it.sy = 32'(f[1] - d[1]); it.sz = 32'(f[2] - d[2]);
        it.has_pair = hp;
        it.last_pair = lp;
        pending_pairs.push_back(it);
    endtask

    task automatic push_raw(bit hp, bit lp);
        pair_item_t it;
        it = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, hp, lp};
        pending_pairs.push_back(it);
    endtask

    // one set of pairs, mostly near neighbours with random image shifts
    task automatic push_set(int len, int npairs);
        longint f[3], d[3];
        int     pick;
        for (int p = 0; p < npairs; p++) begin
            if ($urandom_range(0, 9) == 0)
                push_raw(0, 0);   // empty item inside the set
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                push_raw(1, p == npairs - 1);
            end else begin
                for (int k = 0; k < 3; k++) begin
                    f[k] = $urandom_range(0, len * UNIT);
                    if (pick == 1)
                        d[k] = longint'($urandom_range(0, len * UNIT)) - len * UNIT / 2;
                    else
                        d[k] = longint'($urandom_range(0, 6 * UNIT)) - 3 * UNIT;
                    if ($urandom_range(0, 3) == 0)
                        d[k] += ($urandom_range(0, 1) ? 1 : -1) * len * UNIT;
                end
                push_pair(f, d, 1, p == npairs - 1);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || in_valid || expected_energy.size() > 0)
            @(posedge i_clk);
        // let a trailing pair without a result finish before the next write
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        longint    f[3], d[3];
        int        len, mode;
        bit [31:0] sig, cutr, eps;
        lj_regs = '{default: 0};
        lj_sum = 0;
        lj_overlap = 0;
        lj_clip = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // registers at reset: every closing item must give zero
        push_raw(0, 0);
        push_raw(0, 1);
        push_raw(1, 1);
        push_raw(1, 0);
        push_raw(0, 1);
        wait_drained();

        // directed: box of 8, sigma 1, cutoff 4.5, eps 1
        set_box(8, 0, 32'h0001_0000, 32'h0004_8000, 32'h0001_0000);
        f = '{3 * UNIT, UNIT, 2 * UNIT};
        d = '{UNIT + UNIT / 10, 0, 0};
        push_pair(f, d, 1, 0);
        d = '{4 * UNIT, 0, 0};          // exactly plus one half
        push_pair(f, d, 1, 0);
        d = '{-4 * UNIT, 0, 0};         // exactly minus one half
        push_pair(f, d, 1, 1);
        d = '{0, 0, 0};                 // overlap
        push_pair(f, d, 1, 1);
        d = '{UNIT / 10, 0, 0};         // huge term clips
        push_pair(f, d, 1, 1);
        d = '{UNIT / 10, 0, 0};         // two clipped terms saturate the sum
        push_pair(f, d, 1, 0);
        push_pair(f, d, 1, 1);
        d = '{3 * UNIT, 3 * UNIT, 3 * UNIT};  // outside the cutoff
        push_pair(f, d, 1, 1);
        d = '{5 * UNIT, -UNIT, 12 * UNIT};   // wraps into range
        push_pair(f, d, 1, 1);
        push_raw(0, 1);                 // empty set
        push_raw(0, 0);                 // nothing at all
        pending_pairs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1});
        pending_pairs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1});
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            mode = ph % 4;
            snd_pct = (mode == 1) ? 66 : (mode == 3) ? 33 : 0;
            rcv_pct = (mode == 2) ? 66 : (mode == 3) ? 33 : 0;
            len  = $urandom_range(3, 1000);
            sig  = $urandom_range(UNIT / 2, 3 * UNIT);
            cutr = $urandom_range(UNIT, 4 * UNIT);
            eps  = $urandom_range(1, 20 * UNIT);
            case (ph)
                3: eps = 6;                          // eps just below the floor
                5: sig = 32'hFFFF_0000;              // negative sigma
                7: eps = 32'h7FFF_FFFF;              // output scale overflows
                default: ;
            endcase
            if (ph < 10)
                len = (ph % 3 == 0) ? $urandom_range(3, 12) : len;
            set_box(len, ph % 2, sig, cutr, eps);
            if (ph == 9) begin
                // every register at its all-ones extreme
                for (int r = 0; r < 8; r++)
                    write_reg(t_reg_idx'(r), '1);
            end else if (ph == 10) begin
                for (int r = 0; r < 8; r++)
                    write_reg(t_reg_idx'(r), {$urandom, $urandom});
            end
            while (pending_pairs.size() < 150)
                push_set(len, ($urandom_range(0, 15) == 0) ? 20 : $urandom_range(1, 6));
            for (int n = 0; n < 6; n++)
                push_raw($urandom_range(0, 1), $urandom_range(0, 1));
            wait_drained();
        end

        $display("%0d items accepted, %0d results checked over 14 settings",
                 n_accepted, n_results);
        $display("%0d results with overlap, %0d saturated, %0d mismatches",
                 n_overlap, n_sat, n_mismatch);
        if (n_mismatch == 0 && expected_energy.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### lennard_jones_pair_energy.f
hdl/ljpe_pkg.sv
hdl/ljpe_datapath.sv
hdl/ljpe_ctrl.sv
hdl/lennard_jones_pair_energy.sv
tb/tb_lennard_jones_pair_energy.sv
